// ===== rtl/pulse_energy_meter_core_defines.svh =====
// Assertion macros shared by the pulse energy meter RTL.
// Depends on nothing; take in with `include where checks are written.
`ifndef PULSE_ENERGY_METER_CORE_DEFINES_SVH
`define PULSE_ENERGY_METER_CORE_DEFINES_SVH

// Check that post holds in the same cycle as pre.
`define PEM_ASSERT_NOW(label, ck, rn, pre, post) \
  label: assert property (@(posedge ck) disable iff (!rn) (pre) |-> (post)) \
    else $error("pem: same-cycle check failed");

// Check that post holds in the cycle after pre.
`define PEM_ASSERT_NEXT(label, ck, rn, pre, post) \
  label: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) \
    else $error("pem: next-cycle check failed");

`endif

// ===== rtl/pem_pkg.sv =====
// Types, constants and codes for the pulse energy meter.
// Depends on nothing; used by every module of the block.
package pem_pkg;

  localparam int TIME_W  = 32;
  localparam int CMP_W   = (TIME_W > 32) ? TIME_W : 32;
  localparam int VAL_W   = 32;
  localparam int PPK_W   = 17;
  localparam int SCALE_W = 14;
  localparam int NUM_W   = 46;
  localparam int HI_W    = NUM_W - VAL_W;
  localparam int DIV_W   = VAL_W + PPK_W;

  localparam int DIV_STEPS = VAL_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [VAL_W-1:0]   POWER_NUM    = 32'd3600000000;
  localparam logic [VAL_W-1:0]   ALL_ONES     = 32'hFFFF_FFFF;
  localparam logic [SCALE_W-1:0] ENERGY_SCALE = 14'd10000;

  localparam logic [VAL_W-1:0] SEND_INTERVAL_RST = 32'd5000;
  localparam logic [PPK_W-1:0] PPK_RST           = 17'd1000;
  localparam logic [VAL_W-1:0] WATT_LIMIT_RST    = 32'd10000;

  typedef enum logic [1:0] {
    ACT_PULSE   = 2'd0,
    ACT_TICK    = 2'd1,
    ACT_RESTORE = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    CFG_SEND_INTERVAL  = 2'd0,
    CFG_PULSES_PER_KWH = 2'd1,
    CFG_WATT_LIMIT     = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    RPT_POWER   = 2'd0,
    RPT_COUNT   = 2'd1,
    RPT_ENERGY  = 2'd2,
    RPT_REQUEST = 2'd3
  } report_kind_t;

  typedef enum logic [2:0] {
    CMD_POWER_SET = 3'd0,
    CMD_POWER_DIV = 3'd1,
    CMD_RESTORE   = 3'd2,
    CMD_REQUEST   = 3'd3,
    CMD_REPORT    = 3'd4
  } cmd_kind_t;

  typedef struct packed {
    logic [VAL_W-1:0] send_interval;
    logic [PPK_W-1:0] ppk;
    logic [VAL_W-1:0] watt_limit;
  } cfg_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [VAL_W-1:0] data;
  } cmd_t;

  typedef struct packed {
    logic             start;
    logic [HI_W-1:0]  hi;
    logic [VAL_W-1:0] lo;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [VAL_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/pem_front.sv =====
// Front end: configuration registers, input acceptance and classification.
// Depends on pem_pkg; feeds commands to pem_queue.
module pem_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_action,
  input  logic [31:0]                 in_now_ms,
  input  logic [31:0]                 in_restored_count,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [31:0]                 cfg_data,
  input  logic                        q_full,
  output logic                        q_push,
  output pem_pkg::cmd_t               q_cmd,
  output pem_pkg::cfg_t               cfg
);

  logic [pem_pkg::TIME_W-1:0] last_pulse_r, last_pulse_nxt;
  logic [pem_pkg::TIME_W-1:0] last_report_r, last_report_nxt;
  logic                       restored_r, restored_nxt;
  pem_pkg::cfg_t              cfg_r, cfg_nxt;

  logic                       accept;
  logic [pem_pkg::TIME_W-1:0] now_t;
  logic [pem_pkg::TIME_W-1:0] interval;
  logic [pem_pkg::TIME_W-1:0] elapsed;
  logic                       due;

  assign accept   = in_valid && !q_full;
  assign in_stall = q_full;
  assign now_t    = pem_pkg::TIME_W'(in_now_ms);
  assign interval = now_t - last_pulse_r;
  assign elapsed  = now_t - last_report_r;
  assign due      = pem_pkg::CMP_W'(elapsed) > pem_pkg::CMP_W'(cfg_r.send_interval);
  assign cfg      = cfg_r;

  always_comb begin
    last_pulse_nxt  = last_pulse_r;
    last_report_nxt = last_report_r;
    restored_nxt    = restored_r;
    cfg_nxt         = cfg_r;
    q_push          = 1'b0;
    q_cmd.kind      = pem_pkg::CMD_REQUEST;
    q_cmd.data      = '0;

    if (cfg_we) begin
      case (pem_pkg::cfg_index_t'(cfg_index))
        pem_pkg::CFG_SEND_INTERVAL:  cfg_nxt.send_interval = cfg_data;
        pem_pkg::CFG_PULSES_PER_KWH: cfg_nxt.ppk = cfg_data[pem_pkg::PPK_W-1:0];
        pem_pkg::CFG_WATT_LIMIT:     cfg_nxt.watt_limit = cfg_data;
        default: ;
      endcase
    end

    if (accept) begin
      case (pem_pkg::action_t'(in_action))
        pem_pkg::ACT_PULSE: begin
          last_pulse_nxt = now_t;
          q_push         = 1'b1;
          // Settle the saturated cases here so the back end only divides.
          if (interval == '0 || cfg_r.ppk == '0) begin
            q_cmd.kind = pem_pkg::CMD_POWER_SET;
            q_cmd.data = pem_pkg::ALL_ONES;
          end else if (pem_pkg::CMP_W'(interval) > pem_pkg::CMP_W'(pem_pkg::POWER_NUM)) begin
            q_cmd.kind = pem_pkg::CMD_POWER_SET;
            q_cmd.data = '0;
          end else begin
            q_cmd.kind = pem_pkg::CMD_POWER_DIV;
            q_cmd.data = pem_pkg::VAL_W'(interval);
          end
        end
        pem_pkg::ACT_RESTORE: begin
          restored_nxt = 1'b1;
          q_push       = 1'b1;
          q_cmd.kind   = pem_pkg::CMD_RESTORE;
          q_cmd.data   = in_restored_count;
        end
        pem_pkg::ACT_TICK: begin
          if (due) begin
            last_report_nxt = now_t;
            q_push          = 1'b1;
            q_cmd.kind      = restored_r ? pem_pkg::CMD_REPORT : pem_pkg::CMD_REQUEST;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_pulse_r      <= '0;
      last_report_r     <= '0;
      restored_r        <= 1'b0;
      cfg_r.send_interval <= pem_pkg::SEND_INTERVAL_RST;
      cfg_r.ppk         <= pem_pkg::PPK_RST;
      cfg_r.watt_limit  <= pem_pkg::WATT_LIMIT_RST;
    end else begin
      last_pulse_r  <= last_pulse_nxt;
      last_report_r <= last_report_nxt;
      restored_r    <= restored_nxt;
      cfg_r         <= cfg_nxt;
    end
  end

endmodule

// ===== rtl/pem_queue.sv =====
// Short command queue between the front and back ends.
// Depends on pem_pkg and the assertion macro header.
`include "pulse_energy_meter_core_defines.svh"

module pem_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_push,
  input  pem_pkg::cmd_t q_push_cmd,
  output logic          q_full,
  input  logic          q_pop,
  output logic          q_avail,
  output pem_pkg::cmd_t q_pop_cmd
);

  pem_pkg::cmd_t               mem [pem_pkg::Q_DEPTH];
  logic [pem_pkg::Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [pem_pkg::Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [pem_pkg::Q_CNT_W-1:0] cnt_r, cnt_nxt;

  assign q_full    = cnt_r == pem_pkg::Q_CNT_W'(pem_pkg::Q_DEPTH);
  assign q_avail   = cnt_r != '0;
  assign q_pop_cmd = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (q_push) begin
      wr_ptr_nxt = (wr_ptr_r == pem_pkg::Q_PTR_W'(pem_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == pem_pkg::Q_PTR_W'(pem_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (q_push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (q_pop && !q_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      mem[wr_ptr_r] <= q_push_cmd;
    end
  end

  `PEM_ASSERT_NOW(a_push_not_full, clk, rst_n, q_push, !q_full)
  `PEM_ASSERT_NOW(a_pop_not_empty, clk, rst_n, q_pop, q_avail)
  `PEM_ASSERT_NOW(a_cnt_in_range, clk, rst_n, 1'b1, cnt_r <= pem_pkg::Q_CNT_W'(pem_pkg::Q_DEPTH))

endmodule

// ===== rtl/pem_div.sv =====
// Shared restoring divider, one quotient bit per cycle, saturating at 32 bits.
// Depends on pem_pkg; used by pem_back for power and energy.
module pem_div (
  input  logic              clk,
  input  logic              rst_n,
  input  pem_pkg::div_req_t req,
  output pem_pkg::div_rsp_t rsp
);

  logic [pem_pkg::DIV_W-1:0]     rem_r, rem_nxt;
  logic [pem_pkg::VAL_W-1:0]     quo_r, quo_nxt;
  logic [pem_pkg::DIV_W-1:0]     dsr_r, dsr_nxt;
  logic [pem_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;

  logic [pem_pkg::DIV_W:0]       rem_sh;
  logic [pem_pkg::DIV_W:0]       diff;
  logic                          ge;

  assign rem_sh = {rem_r, quo_r[pem_pkg::VAL_W-1]};
  assign diff   = rem_sh - {1'b0, dsr_r};
  assign ge     = rem_sh >= {1'b0, dsr_r};

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      // A high part at or above the divisor means the quotient needs more than 32 bits.
      if (pem_pkg::DIV_W'(req.hi) >= req.divisor) begin
        quo_nxt  = pem_pkg::ALL_ONES;
        done_nxt = 1'b1;
        busy_nxt = 1'b0;
      end else begin
        rem_nxt  = pem_pkg::DIV_W'(req.hi);
        quo_nxt  = req.lo;
        dsr_nxt  = req.divisor;
        cnt_nxt  = pem_pkg::DIV_CNT_W'(pem_pkg::DIV_STEPS - 1);
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      rem_nxt = ge ? diff[pem_pkg::DIV_W-1:0] : rem_sh[pem_pkg::DIV_W-1:0];
      quo_nxt = {quo_r[pem_pkg::VAL_W-2:0], ge};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

endmodule

// ===== rtl/pem_back.sv =====
// Back end: meter state, power and energy sequencing, output register.
// Depends on pem_pkg, pem_div and the assertion macro header.
`include "pulse_energy_meter_core_defines.svh"

module pem_back (
  input  logic          clk,
  input  logic          rst_n,
  input  pem_pkg::cfg_t cfg,
  input  logic          q_avail,
  input  pem_pkg::cmd_t q_cmd,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [1:0]    out_report_kind,
  output logic [31:0]   out_report_value,
  output logic          out_last_of_run
);

  typedef enum logic [3:0] {
    B_IDLE, B_PMUL, B_PGO, B_PWAIT, B_REQ, B_RPW, B_RCNT,
    B_EMUL, B_EGO, B_EWAIT, B_EEMIT
  } state_t;

  state_t                    state_r, state_nxt;
  logic [pem_pkg::VAL_W-1:0] pulse_total_r, pulse_total_nxt;
  logic [pem_pkg::VAL_W-1:0] power_now_r, power_now_nxt;
  logic [pem_pkg::VAL_W-1:0] power_rep_r, power_rep_nxt;
  logic [pem_pkg::VAL_W-1:0] count_rep_r, count_rep_nxt;
  logic [pem_pkg::VAL_W-1:0] itv_r, itv_nxt;
  logic [pem_pkg::DIV_W-1:0] prod_r, prod_nxt;

  logic                      out_valid_r, out_valid_nxt;
  pem_pkg::report_kind_t     out_kind_r, out_kind_nxt;
  logic [pem_pkg::VAL_W-1:0] out_value_r, out_value_nxt;
  logic                      out_last_r, out_last_nxt;

  logic                      out_free;
  logic                      emit;
  pem_pkg::report_kind_t     emit_kind;
  logic [pem_pkg::VAL_W-1:0] emit_value;
  logic                      emit_last;
  logic                      energy_op;

  pem_pkg::div_req_t         div_req;
  pem_pkg::div_rsp_t         div_rsp;

  pem_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign energy_op = state_r == B_EGO;

  assign div_req.start   = (state_r == B_PGO) || (state_r == B_EGO);
  assign div_req.hi      = energy_op ? prod_r[pem_pkg::NUM_W-1:pem_pkg::VAL_W] : '0;
  assign div_req.lo      = energy_op ? prod_r[pem_pkg::VAL_W-1:0] : pem_pkg::POWER_NUM;
  assign div_req.divisor = energy_op ? pem_pkg::DIV_W'(cfg.ppk) : prod_r;

  always_comb begin
    state_nxt       = state_r;
    pulse_total_nxt = pulse_total_r;
    power_now_nxt   = power_now_r;
    power_rep_nxt   = power_rep_r;
    count_rep_nxt   = count_rep_r;
    itv_nxt         = itv_r;
    prod_nxt        = prod_r;
    q_pop           = 1'b0;
    emit            = 1'b0;
    emit_kind       = pem_pkg::RPT_POWER;
    emit_value      = '0;
    emit_last       = 1'b0;

    case (state_r)
      B_IDLE: begin
        if (q_avail) begin
          q_pop = 1'b1;
          case (q_cmd.kind)
            pem_pkg::CMD_POWER_SET: begin
              power_now_nxt   = q_cmd.data;
              pulse_total_nxt = pulse_total_r + 1'b1;
            end
            pem_pkg::CMD_POWER_DIV: begin
              itv_nxt         = q_cmd.data;
              pulse_total_nxt = pulse_total_r + 1'b1;
              state_nxt       = B_PMUL;
            end
            pem_pkg::CMD_RESTORE: begin
              pulse_total_nxt = q_cmd.data;
              count_rep_nxt   = q_cmd.data;
            end
            pem_pkg::CMD_REQUEST: state_nxt = B_REQ;
            pem_pkg::CMD_REPORT:  state_nxt = B_RPW;
            default: ;
          endcase
        end
      end
      B_PMUL: begin
        prod_nxt  = pem_pkg::DIV_W'(itv_r) * pem_pkg::DIV_W'(cfg.ppk);
        state_nxt = B_PGO;
      end
      B_PGO: state_nxt = B_PWAIT;
      B_PWAIT: begin
        if (div_rsp.done) begin
          power_now_nxt = div_rsp.quotient;
          state_nxt     = B_IDLE;
        end
      end
      B_REQ: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_kind = pem_pkg::RPT_REQUEST;
          emit_last = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      B_RPW: begin
        if (power_now_r == power_rep_r) begin
          state_nxt = B_RCNT;
        end else if (power_now_r >= cfg.watt_limit) begin
          // Out of range: record it as sent, report nothing.
          power_rep_nxt = power_now_r;
          state_nxt     = B_RCNT;
        end else if (out_free) begin
          emit          = 1'b1;
          emit_kind     = pem_pkg::RPT_POWER;
          emit_value    = power_now_r;
          emit_last     = pulse_total_r == count_rep_r;
          power_rep_nxt = power_now_r;
          state_nxt     = B_RCNT;
        end
      end
      B_RCNT: begin
        if (pulse_total_r == count_rep_r) begin
          state_nxt = B_IDLE;
        end else if (out_free) begin
          emit          = 1'b1;
          emit_kind     = pem_pkg::RPT_COUNT;
          emit_value    = pulse_total_r;
          count_rep_nxt = pulse_total_r;
          state_nxt     = B_EMUL;
        end
      end
      B_EMUL: begin
        prod_nxt  = pem_pkg::DIV_W'(pem_pkg::NUM_W'(pulse_total_r)
                  * pem_pkg::NUM_W'(pem_pkg::ENERGY_SCALE)
                  + pem_pkg::NUM_W'(cfg.ppk >> 1));
        state_nxt = B_EGO;
      end
      B_EGO: state_nxt = B_EWAIT;
      B_EWAIT: begin
        if (div_rsp.done) begin
          state_nxt = B_EEMIT;
        end
      end
      B_EEMIT: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_kind  = pem_pkg::RPT_ENERGY;
          emit_value = div_rsp.quotient;
          emit_last  = 1'b1;
          state_nxt  = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase

    out_valid_nxt = emit || (out_valid_r && out_stall);
    out_kind_nxt  = emit ? emit_kind : out_kind_r;
    out_value_nxt = emit ? emit_value : out_value_r;
    out_last_nxt  = emit ? emit_last : out_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= B_IDLE;
      pulse_total_r <= '0;
      power_now_r   <= '0;
      power_rep_r   <= '0;
      count_rep_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      pulse_total_r <= pulse_total_nxt;
      power_now_r   <= power_now_nxt;
      power_rep_r   <= power_rep_nxt;
      count_rep_r   <= count_rep_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    itv_r       <= itv_nxt;
    prod_r      <= prod_nxt;
    out_kind_r  <= out_kind_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_report_kind  = out_kind_r;
  assign out_report_value = out_value_r;
  assign out_last_of_run  = out_last_r;

  `PEM_ASSERT_NOW(a_idle_div_quiet, clk, rst_n, state_r == B_IDLE, !div_rsp.busy)
  `PEM_ASSERT_NOW(a_done_when_waiting, clk, rst_n, div_rsp.done,
                  (state_r == B_PWAIT) || (state_r == B_EWAIT))
  `PEM_ASSERT_NOW(a_energy_ends_run, clk, rst_n,
                  out_valid_r && (out_kind_r == pem_pkg::RPT_ENERGY), out_last_r)
  `PEM_ASSERT_NEXT(a_count_then_energy, clk, rst_n,
                   emit && (emit_kind == pem_pkg::RPT_COUNT), state_r == B_EMUL)

endmodule

// ===== rtl/pulse_energy_meter_core.sv =====
// Top level of the pulse energy meter: ports, configuration handshake, wiring.
// Depends on pem_pkg, pem_front, pem_queue and pem_back.
//
// Pulse energy meter for an S0 output. Send one word per event: a meter pulse
// (action 0) stamped with now_ms, a tick (action 1), or a restore of the
// pulse count (action 2); action 3 is dropped. A pulse measures the time
// since the previous pulse and turns it into watts as
// 3600000000 / (interval * pulses_per_kwh), truncated, saturating to all
// ones for a zero interval or zero pulses_per_kwh. A tick that finds more
// than send_interval_ms elapsed since the last round (modular time) starts a
// round: before any restore it sends one count request; after it, it sends
// the power if changed and below the watt limit, then the count and the
// energy in 1/10000 kWh if the count changed. last_of_run marks the final
// word of a round. The front end classifies each word in the cycle it is
// accepted and parks it in a two-entry command queue, so in_stall rises only
// when that queue is full. Ticks that are not due, and action 3, never reach
// the back end. The back end executes one command at a time: restores and
// saturated pulses update the meter state directly, a count request and a
// report round wait for the output register under any output stall, and a
// pulse that needs a division and the energy of a report round wait on the
// shared 32-step restoring divider. Results sit in one output register,
// which the back end refills as soon as the current word is taken.
// Configuration writes are always ready and belong in idle periods. There
// is no clearing pass after reset.
module pulse_energy_meter_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_now_ms,
  input  logic [31:0] in_restored_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_report_kind,
  output logic [31:0] out_report_value,
  output logic        out_last_of_run,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic          cfg_we;
  logic          q_full;
  logic          q_push;
  logic          q_pop;
  logic          q_avail;
  pem_pkg::cmd_t push_cmd;
  pem_pkg::cmd_t pop_cmd;
  pem_pkg::cfg_t cfg;

  // Registers live in flops and are always free to take a word.
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  pem_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_now_ms         (in_now_ms),
    .in_restored_count (in_restored_count),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_cmd             (push_cmd),
    .cfg               (cfg)
  );

  pem_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_push     (q_push),
    .q_push_cmd (push_cmd),
    .q_full     (q_full),
    .q_pop      (q_pop),
    .q_avail    (q_avail),
    .q_pop_cmd  (pop_cmd)
  );

  pem_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .q_avail          (q_avail),
    .q_cmd            (pop_cmd),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_report_kind  (out_report_kind),
    .out_report_value (out_report_value),
    .out_last_of_run  (out_last_of_run)
  );

endmodule

// ===== tb/tb_pulse_energy_meter_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for pulse_energy_meter_core: pulse, tick and restore words
// against a cycle-free predictor of power, count and energy reports.
// Depends on pem_pkg and the pulse_energy_meter_core RTL.
module tb_pulse_energy_meter_core;

  localparam logic [1:0] UNKNOWN_ACTION = 2'd3;
  localparam int SETTLE_CYCLES = 100;   // margin for the longest command to finish
  localparam int LONG_HOLD     = 400;   // receiver hold-off that backs up the queue

  typedef struct {
    logic [1:0]  action;
    logic [31:0] now;
    logic [31:0] restored;
  } meter_word_t;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] value;
    logic        last;
  } report_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_action = '0;
  logic [31:0] in_now_ms = '0;
  logic [31:0] in_restored_count = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_report_kind;
  logic [31:0] out_report_value;
  logic        out_last_of_run;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  pulse_energy_meter_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_now_ms         (in_now_ms),
    .in_restored_count (in_restored_count),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_report_kind   (out_report_kind),
    .out_report_value  (out_report_value),
    .out_last_of_run   (out_last_of_run),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Words waiting to be offered, and reports the predictor says must come out.
  meter_word_t word_backlog[$];
  report_t     expected_reports[$];
  meter_word_t held_word;
  report_t     want;

  // Predictor copy of the configuration registers (reset values).
  logic [31:0] send_gap_ms  = pem_pkg::SEND_INTERVAL_RST;
  logic [16:0] ppk          = pem_pkg::PPK_RST;
  logic [31:0] watt_ceiling = pem_pkg::WATT_LIMIT_RST;

  // Predictor copy of the meter state.
  logic [31:0] last_pulse_ms = '0;
  logic [31:0] pulse_count   = '0;
  logic [31:0] power_est     = '0;
  logic [31:0] power_sent    = '0;
  logic [31:0] count_sent    = '0;
  logic        count_loaded  = 1'b0;
  logic [31:0] round_ms      = '0;

  // Traffic shaping.
  logic        tx_idle_en  = 1'b1;
  logic        rx_idle_en  = 1'b1;
  int unsigned tx_gap      = 0;
  int unsigned rx_gap      = 0;
  logic        hold_armed  = 1'b0;
  logic        hold_taken  = 1'b0;
  int unsigned hold_cnt    = 0;

  int unsigned mismatch_count = 0;
  logic [31:0] sim_ms = '0;   // running millisecond clock for random words

  // Work out the reports one accepted word causes and queue them in order.
  task automatic predict_reports(input meter_word_t w);
    report_t     round[$];
    report_t     r;
    logic [31:0] span;
    logic [63:0] prod;
    logic [63:0] quo;
    begin
      case (w.action)
        pem_pkg::ACT_PULSE: begin
          span = w.now - last_pulse_ms;
          if (span == 32'd0 || ppk == 17'd0) begin
            power_est = pem_pkg::ALL_ONES;
          end else if (span > pem_pkg::POWER_NUM) begin
            power_est = '0;
          end else begin
            prod = 64'(span) * 64'(ppk);
            quo = 64'(pem_pkg::POWER_NUM) / prod;
            power_est = quo[31:0];
          end
          last_pulse_ms = w.now;
          pulse_count = pulse_count + 32'd1;
        end
        pem_pkg::ACT_RESTORE: begin
          pulse_count = w.restored;
          count_sent = w.restored;
          count_loaded = 1'b1;
        end
        pem_pkg::ACT_TICK: begin
          span = w.now - round_ms;
          if (span > send_gap_ms) begin
            if (count_loaded) begin
              if (power_est != power_sent) begin
                // Power at or above the ceiling is swallowed but still marked sent.
                if (power_est < watt_ceiling) begin
                  r.kind = pem_pkg::RPT_POWER; r.value = power_est; r.last = 1'b0;
                  round.push_back(r);
                end
                power_sent = power_est;
              end
              if (pulse_count != count_sent) begin
                r.kind = pem_pkg::RPT_COUNT; r.value = pulse_count; r.last = 1'b0;
                round.push_back(r);
                if (ppk == 17'd0) begin
                  r.value = pem_pkg::ALL_ONES;
                end else begin
                  quo = (64'(pulse_count) * 64'(pem_pkg::ENERGY_SCALE) + 64'(ppk >> 1))
                        / 64'(ppk);
                  r.value = (quo > 64'(pem_pkg::ALL_ONES)) ? pem_pkg::ALL_ONES : quo[31:0];
                end
                r.kind = pem_pkg::RPT_ENERGY;
                round.push_back(r);
                count_sent = pulse_count;
              end
            end else begin
              r.kind = pem_pkg::RPT_REQUEST; r.value = '0; r.last = 1'b0;
              round.push_back(r);
            end
            round_ms = w.now;
          end
        end
        default: ;   // unknown action: drop
      endcase
      if (round.size() != 0) round[round.size() - 1].last = 1'b1;
      foreach (round[i]) expected_reports.push_back(round[i]);
    end
  endtask

  // Sender: hold the word while stalled, otherwise advance to the next one or idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) predict_reports(held_word);
      if (tx_gap != 0) begin
        tx_gap <= tx_gap - 1;
        in_valid <= 1'b0;
      end else if (word_backlog.size() != 0) begin
        held_word = word_backlog.pop_front();
        in_action <= held_word.action;
        in_now_ms <= held_word.now;
        in_restored_count <= held_word.restored;
        in_valid <= 1'b1;
        if (tx_idle_en && $urandom_range(0, 5) == 0) tx_gap <= $urandom_range(1, 15);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, served once after the stimulus arms it.
  always @(posedge clk) begin
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (hold_armed && !hold_taken) begin
      hold_cnt <= LONG_HOLD;
      hold_taken <= 1'b1;
    end
  end

  // Receiver: check each taken report against the oldest expectation, then
  // decide the stall for the next cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_reports.size() == 0) begin
        mismatch_count <= mismatch_count + 1;
        if (mismatch_count < 10)
          $display("unexpected report: kind %0d value %0h last %0b",
                   out_report_kind, out_report_value, out_last_of_run);
      end else begin
        want = expected_reports.pop_front();
        if (out_report_kind !== want.kind || out_report_value !== want.value ||
            out_last_of_run !== want.last) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10)
            $display("report mismatch: kind %0d/%0d value %0h/%0h last %0b/%0b (exp/got)",
                     want.kind, out_report_kind, want.value, out_report_value,
                     want.last, out_last_of_run);
        end
      end
    end
    if (rx_gap != 0) begin
      rx_gap <= rx_gap - 1;
    end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
      rx_gap <= $urandom_range(1, 15);
    end
    out_stall <= (hold_cnt != 0) || (rx_gap != 0);
  end

  task automatic add_word(input logic [1:0] action, input logic [31:0] now,
                          input logic [31:0] restored);
    meter_word_t w;
    begin
      w.action = action;
      w.now = now;
      w.restored = restored;
      word_backlog.push_back(w);
    end
  endtask

  // Mostly well-formed traffic on a running clock: pulses, due ticks and
  // occasional restores; a little noise with random time stamps and junk actions.
  task automatic queue_random_words(input int count);
    meter_word_t w;
    int unsigned pick;
    begin
      for (int i = 0; i < count; i++) begin
        pick = $urandom_range(0, 99);
        w.restored = $urandom;
        if (pick < 45) begin
          w.action = pem_pkg::ACT_PULSE;
          sim_ms += ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : $urandom_range(1, 6000);
        end else if (pick < 85) begin
          w.action = pem_pkg::ACT_TICK;
          sim_ms += ($urandom_range(0, 3) == 0) ? $urandom_range(0, 50)
                                                : send_gap_ms + $urandom_range(1, 500);
        end else if (pick < 93) begin
          w.action = pem_pkg::ACT_RESTORE;
          if ($urandom_range(0, 1) == 0) w.restored = $urandom_range(0, 1000);
        end else if (pick < 97) begin
          w.action = ($urandom_range(0, 1) == 0) ? pem_pkg::ACT_PULSE : pem_pkg::ACT_TICK;
          sim_ms = $urandom;
        end else begin
          w.action = UNKNOWN_ACTION;
        end
        w.now = sim_ms;
        word_backlog.push_back(w);
      end
    end
  endtask

  // Write one register; the block must be idle.
  task automatic write_reg(input pem_pkg::cfg_index_t idx, input logic [31:0] val);
    begin
      @(posedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data <= val;
      do @(posedge clk); while (!cfg_ready);
      case (idx)
        pem_pkg::CFG_SEND_INTERVAL:  send_gap_ms = val;
        pem_pkg::CFG_PULSES_PER_KWH: ppk = val[16:0];
        pem_pkg::CFG_WATT_LIMIT:     watt_ceiling = val;
        default: ;
      endcase
      cfg_valid <= 1'b0;
    end
  endtask

  // Wait until every word is taken and every report has come, then let the
  // back end finish any command that makes no report.
  task automatic wait_drained();
    begin
      do @(posedge clk);
      while (word_backlog.size() != 0 || in_valid || expected_reports.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clk);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under reset configuration.
    add_word(pem_pkg::ACT_TICK, 32'd6000, 32'd0);      // round before restore: request
    add_word(pem_pkg::ACT_TICK, 32'd11000, 32'd0);     // exactly the interval: not due
    add_word(UNKNOWN_ACTION, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_word(pem_pkg::ACT_PULSE, 32'd100, 32'd0);      // pulse before restore
    add_word(pem_pkg::ACT_PULSE, 32'd100, 32'd0);      // zero interval saturates
    add_word(pem_pkg::ACT_TICK, 32'd11001, 32'd0);     // still unrestored: request
    add_word(pem_pkg::ACT_RESTORE, 32'd0, 32'hFFFF_FFFE);
    add_word(pem_pkg::ACT_PULSE, 32'd3700, 32'd0);
    add_word(pem_pkg::ACT_TICK, 32'd20000, 32'd0);     // power, count, saturated energy
    add_word(pem_pkg::ACT_PULSE, 32'd3701, 32'd0);     // count wraps, power too high
    add_word(pem_pkg::ACT_TICK, 32'd30000, 32'd0);     // power suppressed, count reported
    add_word(pem_pkg::ACT_TICK, 32'd40000, 32'd0);     // due but nothing changed
    add_word(pem_pkg::ACT_PULSE, 32'hFFFF_FF00, 32'd0); // interval beyond numerator
    add_word(pem_pkg::ACT_PULSE, 32'h0000_0100, 32'd0); // time wrap
    add_word(pem_pkg::ACT_TICK, 32'hFFFF_FFFF, 32'd0);
    add_word(pem_pkg::ACT_TICK, 32'h0000_0010, 32'd0); // wrapped elapsed, not due
    add_word(pem_pkg::ACT_RESTORE, 32'h0000_0000, 32'd0);
    add_word(pem_pkg::ACT_PULSE, 32'd2048, 32'd0);
    add_word(pem_pkg::ACT_TICK, 32'd6000, 32'd0);
    add_word(pem_pkg::ACT_RESTORE, 32'd0, 32'hFFFF_FFFF);
    add_word(pem_pkg::ACT_TICK, 32'd11002, 32'd0);     // restore made count look sent
    add_word(pem_pkg::ACT_PULSE, 32'd0, 32'd0);
    sim_ms = 32'd0;
    wait_drained();

    // Reports on every due tick; back up the block with a long receiver hold-off.
    write_reg(pem_pkg::CFG_SEND_INTERVAL, 32'd0);
    write_reg(pem_pkg::CFG_PULSES_PER_KWH, 32'd1);
    write_reg(pem_pkg::CFG_WATT_LIMIT, 32'hFFFF_FFFF);
    tx_idle_en = 1'b0;
    add_word(pem_pkg::ACT_RESTORE, sim_ms, 32'd5);
    queue_random_words(40);
    hold_armed = 1'b1;
    wait_drained();
    tx_idle_en = 1'b1;

    // No round can ever be due; every power is at or above the ceiling.
    write_reg(pem_pkg::CFG_SEND_INTERVAL, 32'hFFFF_FFFF);
    write_reg(pem_pkg::CFG_PULSES_PER_KWH, 32'h1_FFFF);
    write_reg(pem_pkg::CFG_WATT_LIMIT, 32'd0);
    queue_random_words(20);
    wait_drained();

    // Zero pulses per kWh: power and energy saturate.
    write_reg(pem_pkg::CFG_SEND_INTERVAL, 32'd1000);
    write_reg(pem_pkg::CFG_PULSES_PER_KWH, 32'd0);
    write_reg(pem_pkg::CFG_WATT_LIMIT, 32'd5000);
    queue_random_words(30);
    wait_drained();

    // Typical settings, no idling on either side.
    write_reg(pem_pkg::CFG_SEND_INTERVAL, $urandom_range(0, 3000));
    write_reg(pem_pkg::CFG_PULSES_PER_KWH, $urandom_range(1, 100000));
    write_reg(pem_pkg::CFG_WATT_LIMIT, $urandom_range(0, 200000));
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    queue_random_words(40);
    wait_drained();

    if (mismatch_count == 0 && expected_reports.size() == 0) begin
      $display("pulse_energy_meter_core verification clean");
    end else begin
      $display("pulse_energy_meter_core verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("pulse_energy_meter_core verification failed");
    $finish;
  end

endmodule
